// ===== hw/rtl/avrm_pkg.sv =====
// Shared types, constants and tables for the volume ramp and noise mixer.
`timescale 1ns / 1ps

package avrm_pkg;

  localparam int DIV_W   = 41;  // signed dividend / quotient width
  localparam int DVS_W   = 18;  // unsigned divisor width
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 52;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_TICK_WAIT,
    ST_NZ_MUL,
    ST_NZ_WDIV,
    ST_NZ_WWAIT,
    ST_NZ_TDIV,
    ST_NZ_TWAIT,
    ST_MAC,
    ST_BQ_END,
    ST_MIX_MUL,
    ST_MIX_DIV,
    ST_MIX_WAIT,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    REG_VOLUME_STEP  = 4'd0,
    REG_NOISE_STEP   = 4'd1,
    REG_POPCORN_STEP = 4'd2,
    REG_RAMP_UP      = 4'd3,
    REG_RAMP_DOWN    = 4'd4,
    REG_UNMUTED      = 4'd5,
    REG_NOM_GAIN     = 4'd6,
    REG_TOGGLE_THR   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_W-1:0]  dividend;
    logic        [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIV_W-1:0]  quotient;
  } div_rsp_t;

  function automatic logic [14:0] vol_table(input logic [4:0] idx);
    logic [14:0] v;
    case (idx)
      5'd0:  v = 15'd0;     5'd1:  v = 15'd100;   5'd2:  v = 15'd200;
      5'd3:  v = 15'd300;   5'd4:  v = 15'd400;   5'd5:  v = 15'd500;
      5'd6:  v = 15'd600;   5'd7:  v = 15'd700;   5'd8:  v = 15'd800;
      5'd9:  v = 15'd900;   5'd10: v = 15'd1000;  5'd11: v = 15'd1900;
      5'd12: v = 15'd2800;  5'd13: v = 15'd3700;  5'd14: v = 15'd4600;
      5'd15: v = 15'd5500;  5'd16: v = 15'd6400;  5'd17: v = 15'd7300;
      5'd18: v = 15'd8200;  5'd19: v = 15'd9100;  5'd20: v = 15'd10000;
      5'd21: v = 15'd11000; 5'd22: v = 15'd12000; 5'd23: v = 15'd13000;
      5'd24: v = 15'd14000; 5'd25: v = 15'd15000; 5'd26: v = 15'd16000;
      5'd27: v = 15'd17000; 5'd28: v = 15'd18000; 5'd29: v = 15'd19000;
      default: v = 15'd20000;
    endcase
    return v;
  endfunction

  function automatic logic [13:0] lvl_table(input logic [3:0] idx);
    logic [13:0] v;
    case (idx)
      4'd0: v = 14'd0;    4'd1: v = 14'd40;   4'd2: v = 14'd80;
      4'd3: v = 14'd270;  4'd4: v = 14'd640;  4'd5: v = 14'd1250;
      4'd6: v = 14'd2160; 4'd7: v = 14'd3430; 4'd8: v = 14'd5120;
      4'd9: v = 14'd7290;
      default: v = 14'd10000;
    endcase
    return v;
  endfunction

  // Q2.14 taps in MAC order x, x1, x2, y1, y2; feedback terms pre-negated
  function automatic logic signed [15:0] hp_coef(input logic stg, input logic [2:0] k);
    logic signed [15:0] c;
    case ({stg, k})
      4'b0_000: c = 16'sd13647;
      4'b0_001: c = -16'sd27294;
      4'b0_010: c = 16'sd13647;
      4'b0_011: c = 16'sd25732;
      4'b0_100: c = -16'sd12472;
      4'b1_000: c = 16'sd14673;
      4'b1_001: c = -16'sd29346;
      4'b1_010: c = 16'sd14673;
      4'b1_011: c = 16'sd27667;
      4'b1_100: c = -16'sd14642;
      default:  c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/audio_volume_ramp_noise_mixer_unit.sv =====
// Top level: volume ramp, telegraph/white noise high-pass mix, stereo output.
`timescale 1ns / 1ps
// A ramp tick runs one divide (none if already on target), a sample with noise off
// one, a noisy sample three divides and two biquad passes before the result is valid.
// Throughput: one beat in flight; the next is taken from the cycle the result rises,
// later while an earlier result is still stalled.
// Reset (rst, synchronous): registers to their defaults, volume 0, telegraph
// sign positive, filter history cleared, no result pending.

module audio_volume_ramp_noise_mixer_unit (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               op,
  input  logic signed [15:0] sample_in,
  input  logic [15:0]        noise_draw,
  input  logic [15:0]        flip_draw,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        stereo_word,
  output logic [14:0]        volume_level,
  output logic               is_muted,
  // register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DW = avrm_pkg::DIV_W;
  localparam int PW = avrm_pkg::PROD_W;
  localparam int AW = avrm_pkg::ACC_W;

  // registers
  logic [4:0]  volume_step;
  logic [3:0]  noise_step;
  logic [3:0]  popcorn_step;
  logic [7:0]  ramp_up_div;
  logic [7:0]  ramp_down_div;
  logic        unmuted;
  logic [14:0] nominal_gain;
  logic [15:0] toggle_thr;

  avrm_pkg::state_t state, state_next;

  logic [14:0]             vol_now;
  logic                    tel_neg;
  logic signed [31:0]      hist [8];
  logic signed [15:0]      sample_r;
  logic [15:0]             draw_r;
  logic signed [DW-1:0]    white;
  logic signed [31:0]      xin;
  logic signed [AW-1:0]    acc;
  logic signed [PW-1:0]    prod;
  logic signed [24:0]      mixed;
  logic                    stg;
  logic [2:0]              cnt;
  logic [31:0]             res_word;
  logic                    up_dir;

  avrm_pkg::div_req_t div_req;
  avrm_pkg::div_rsp_t div_rsp;

  avrm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // derived config values
  logic [14:0] gain;
  logic [17:0] gain5;
  logic [13:0] wl, pl;
  logic        noise_on;
  logic [14:0] target;
  logic [7:0]  d_up, d_dn;
  logic [14:0] gap_up, gap_dn, gap;
  logic        tick_move;

  always_comb begin
    gain     = (nominal_gain == '0) ? 15'd1 : nominal_gain;
    gain5    = {1'b0, gain, 2'b00} + {3'b000, gain};
    wl       = avrm_pkg::lvl_table(noise_step);
    pl       = avrm_pkg::lvl_table(popcorn_step);
    noise_on = (noise_step != '0) || (popcorn_step != '0);
    target   = unmuted ? avrm_pkg::vol_table(volume_step > 5'd30 ? 5'd30 : volume_step)
                       : 15'd0;
    d_up     = (ramp_up_div == '0) ? 8'd1 : ramp_up_div;
    d_dn     = (ramp_down_div == '0) ? 8'd1 : ramp_down_div;
    gap_up   = target - vol_now;
    gap_dn   = vol_now - target;
    // gap clamped up to the divisor so the step is never below 1
    if (vol_now < target) gap = (gap_up < {7'b0, d_up}) ? {7'b0, d_up} : gap_up;
    else                  gap = (gap_dn < {7'b0, d_dn}) ? {7'b0, d_dn} : gap_dn;
    tick_move = (vol_now != target);
  end

  // shared multiplier operand select
  logic [1:0]                          cm1;
  logic [2:0]                          hidx;
  logic signed [31:0]                  mac_op;
  logic signed [16:0]                  draw_c;
  logic signed [avrm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [avrm_pkg::MUL_B_W-1:0] mul_b;
  logic signed [15:0]                  coef;

  always_comb begin
    cm1    = 2'(cnt - 3'd1);
    hidx   = {stg, cm1};
    mac_op = (cnt == '0) ? xin : hist[hidx];
    draw_c = $signed({1'b0, draw_r}) - 17'sd32768;
    coef   = avrm_pkg::hp_coef(stg, cnt);
    case (state)
      avrm_pkg::ST_NZ_MUL: begin
        mul_a = {{16{draw_c[16]}}, draw_c};
        mul_b = {3'b000, wl};
      end
      avrm_pkg::ST_MIX_MUL: begin
        mul_a = {{8{mixed[24]}}, mixed};
        mul_b = {2'b00, vol_now};
      end
      default: begin
        mul_a = {mac_op[31], mac_op};
        mul_b = {coef[15], coef};
      end
    endcase
  end

  // biquad output: floor by 2^14, saturate, then trunc toward zero by 256
  logic signed [AW-15:0] acc_sh;
  logic signed [31:0]    yq;
  logic signed [32:0]    y_adj;
  logic signed [23:0]    ytr;

  always_comb begin
    acc_sh = acc[AW-1:14];
    if (acc_sh > $signed(38'sh7FFF_FFFF))       yq = 32'sh7FFF_FFFF;
    else if (acc_sh < -$signed(38'sh8000_0000)) yq = -32'sh8000_0000;
    else                                        yq = acc_sh[31:0];
    y_adj = yq[31] ? ({yq[31], yq} + 33'sd255) : {yq[31], yq};
    ytr   = 24'(y_adj >>> 8);
  end

  // white plus telegraph, saturated to 32 bits
  logic signed [DW-1:0] tq;
  logic signed [DW:0]   nsum;
  logic signed [31:0]   nsat;
  logic signed [15:0]   s16;

  always_comb begin
    tq   = tel_neg ? -div_rsp.quotient : div_rsp.quotient;
    nsum = {white[DW-1], white} + {tq[DW-1], tq};
    if (nsum > $signed(42'sh7FFF_FFFF))       nsat = 32'sh7FFF_FFFF;
    else if (nsum < -$signed(42'sh8000_0000)) nsat = -32'sh8000_0000;
    else                                      nsat = nsum[31:0];
    if (div_rsp.quotient > $signed(41'sd32767))       s16 = 16'sh7FFF;
    else if (div_rsp.quotient < -$signed(41'sd32768)) s16 = -16'sh8000;
    else                                              s16 = div_rsp.quotient[15:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      avrm_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (op)            state_next = avrm_pkg::ST_TICK;
          else if (noise_on) state_next = avrm_pkg::ST_NZ_MUL;
          else               state_next = avrm_pkg::ST_MIX_MUL;
        end
      end
      avrm_pkg::ST_TICK:      state_next = tick_move ? avrm_pkg::ST_TICK_WAIT
                                                     : avrm_pkg::ST_FIN;
      avrm_pkg::ST_TICK_WAIT: if (div_rsp.done) state_next = avrm_pkg::ST_FIN;
      avrm_pkg::ST_NZ_MUL:    state_next = avrm_pkg::ST_NZ_WDIV;
      avrm_pkg::ST_NZ_WDIV:   state_next = avrm_pkg::ST_NZ_WWAIT;
      avrm_pkg::ST_NZ_WWAIT:  if (div_rsp.done) state_next = avrm_pkg::ST_NZ_TDIV;
      avrm_pkg::ST_NZ_TDIV:   state_next = avrm_pkg::ST_NZ_TWAIT;
      avrm_pkg::ST_NZ_TWAIT:  if (div_rsp.done) state_next = avrm_pkg::ST_MAC;
      avrm_pkg::ST_MAC:       if (cnt == 3'd5) state_next = avrm_pkg::ST_BQ_END;
      avrm_pkg::ST_BQ_END:    state_next = stg ? avrm_pkg::ST_MIX_MUL : avrm_pkg::ST_MAC;
      avrm_pkg::ST_MIX_MUL:   state_next = avrm_pkg::ST_MIX_DIV;
      avrm_pkg::ST_MIX_DIV:   state_next = avrm_pkg::ST_MIX_WAIT;
      avrm_pkg::ST_MIX_WAIT:  if (div_rsp.done) state_next = avrm_pkg::ST_FIN;
      avrm_pkg::ST_FIN:       if (!result_valid || !result_stall) state_next = avrm_pkg::ST_IDLE;
      default:                state_next = avrm_pkg::ST_IDLE;
    endcase
  end

  // outputs to the divider and the item channel
  always_comb begin
    item_stall       = (state != avrm_pkg::ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = {{(DW-15){1'b0}}, gap};
    div_req.divisor  = up_dir ? {10'b0, d_up} : {10'b0, d_dn};
    case (state)
      avrm_pkg::ST_TICK: begin
        div_req.start   = tick_move;
        div_req.divisor = (vol_now < target) ? {10'b0, d_up} : {10'b0, d_dn};
      end
      avrm_pkg::ST_NZ_WDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod[32:0], 8'b0};
        div_req.divisor  = gain5;
      end
      avrm_pkg::ST_NZ_TDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {4'b0, pl, 23'b0};
        div_req.divisor  = {3'b0, gain};
      end
      avrm_pkg::ST_MIX_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DW-1:0];
        div_req.divisor  = {3'b0, gain};
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_step   <= 5'd10;
      noise_step    <= '0;
      popcorn_step  <= '0;
      ramp_up_div   <= '0;
      ramp_down_div <= '0;
      unmuted       <= 1'b0;
      nominal_gain  <= 15'd1000;
      toggle_thr    <= 16'd82;
    end else if (cfg_valid) begin
      case (cfg_index)
        avrm_pkg::REG_VOLUME_STEP:  volume_step   <= cfg_data[4:0];
        avrm_pkg::REG_NOISE_STEP:   noise_step    <= cfg_data[3:0];
        avrm_pkg::REG_POPCORN_STEP: popcorn_step  <= cfg_data[3:0];
        avrm_pkg::REG_RAMP_UP:      ramp_up_div   <= cfg_data[7:0];
        avrm_pkg::REG_RAMP_DOWN:    ramp_down_div <= cfg_data[7:0];
        avrm_pkg::REG_UNMUTED:      unmuted       <= cfg_data[0];
        avrm_pkg::REG_NOM_GAIN:     nominal_gain  <= cfg_data[14:0];
        avrm_pkg::REG_TOGGLE_THR:   toggle_thr    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // datapath, payload regs without reset
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      avrm_pkg::ST_IDLE: begin
        sample_r <= sample_in;
        draw_r   <= noise_draw;
        mixed    <= {{9{sample_in[15]}}, sample_in};
        res_word <= '0;
        stg      <= 1'b0;
        cnt      <= '0;
      end
      avrm_pkg::ST_TICK:     up_dir <= (vol_now < target);
      avrm_pkg::ST_NZ_WWAIT: if (div_rsp.done) white <= div_rsp.quotient;
      avrm_pkg::ST_NZ_TWAIT: if (div_rsp.done) xin <= nsat;
      avrm_pkg::ST_MAC: begin
        if (cnt == 3'd1) acc <= {{(AW-PW){prod[PW-1]}}, prod};
        else if (cnt != '0) acc <= acc + {{(AW-PW){prod[PW-1]}}, prod};
        cnt <= cnt + 3'd1;
      end
      avrm_pkg::ST_BQ_END: begin
        xin <= yq;
        cnt <= '0;
        stg <= 1'b1;
        if (stg) mixed <= {{9{sample_r[15]}}, sample_r} + {ytr[23], ytr};
      end
      avrm_pkg::ST_MIX_WAIT: if (div_rsp.done) res_word <= {s16, s16};
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= avrm_pkg::ST_IDLE;
      vol_now      <= '0;
      tel_neg      <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < 8; i++) hist[i] <= '0;
    end else begin
      state <= state_next;
      if (result_valid && !result_stall) result_valid <= 1'b0;
      case (state)
        avrm_pkg::ST_IDLE: begin
          // telegraph flips only on a noisy sample beat
          if (item_valid && !op && noise_on && (flip_draw < toggle_thr))
            tel_neg <= !tel_neg;
        end
        avrm_pkg::ST_TICK_WAIT: begin
          if (div_rsp.done) begin
            if (up_dir) vol_now <= vol_now + div_rsp.quotient[14:0];
            else        vol_now <= vol_now - div_rsp.quotient[14:0];
          end
        end
        avrm_pkg::ST_BQ_END: begin
          if (stg) begin
            hist[5] <= hist[4]; hist[4] <= xin;
            hist[7] <= hist[6]; hist[6] <= yq;
          end else begin
            hist[1] <= hist[0]; hist[0] <= xin;
            hist[3] <= hist[2]; hist[2] <= yq;
          end
        end
        avrm_pkg::ST_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            stereo_word  <= res_word;
            volume_level <= vol_now;
            is_muted     <= !unmuted && (vol_now == '0);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("block took a beat but did not go busy");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == avrm_pkg::ST_FIN)
    else $error("result raised outside the finish step");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == avrm_pkg::ST_TICK_WAIT || state == avrm_pkg::ST_NZ_WWAIT ||
                      state == avrm_pkg::ST_NZ_TWAIT || state == avrm_pkg::ST_MIX_WAIT))
    else $error("divider finished with no one waiting");
`endif

endmodule

// ===== hw/rtl/avrm_div.sv =====
// Radix-2 restoring signed divider, truncating toward zero.
`timescale 1ns / 1ps

module avrm_div (
  input  logic               clk,
  input  logic               rst,
  input  avrm_pkg::div_req_t req,
  output avrm_pkg::div_rsp_t rsp
);

  localparam int DW  = avrm_pkg::DIV_W;
  localparam int VW  = avrm_pkg::DVS_W;
  localparam int CW  = $clog2(DW);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [DW-1:0] q;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   rem_sh;
  logic [VW-1:0] rem_next;
  logic [DW-1:0] q_next;

  always_comb begin
    rem_sh = {rem, q[DW-1]};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = VW'(rem_sh - {1'b0, dvs});
      q_next   = {q[DW-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[VW-1:0];
      q_next   = {q[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW - 1);
        neg  <= req.dividend[DW-1];
        q    <= req.dividend[DW-1] ? DW'(-req.dividend) : DW'(req.dividend);
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= rem_next;
        q   <= q_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -$signed(q) : $signed(q);

endmodule
